[hw/rtl/tas_pkg.sv]
// ----------------------------------------------------------------------------
// tas_pkg
// Shared widths and constants for the triple-angle sine block.
// ----------------------------------------------------------------------------
package tas_pkg;

    localparam int MAX_STEPS   = 16;
    localparam int STEP_W      = $clog2(MAX_STEPS + 1);

    localparam int ANGLE_W     = 32;
    localparam int SINE_W      = 32;
    localparam int THR_W       = 25;
    localparam logic [THR_W-1:0] THR_RESET = 25'd167772;

    // Reduction magnitude, Q8.56, divided by three one chunk per cycle
    localparam int MAG_W       = 64;
    localparam int CHUNK_W     = 16;
    localparam int NUM_CHUNKS  = MAG_W / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
    localparam int DIV_N_W     = CHUNK_W + 2;
    localparam int DIV_SHIFT   = 19;

    // Shared multiplier operands and product
    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = 31;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    // ceil(2^19 / 3): exact quotient for any numerator below 3 * 2^16
    localparam logic [MUL_B_W-1:0] DIV3_RECIP = 31'd174763;

    localparam logic [MUL_B_W-1:0] Q230_MAX = 31'h7FFF_FFFF;
    localparam logic [MUL_B_W-1:0] ONE_Q230 = 31'h4000_0000;

endpackage

[hw/rtl/triple_angle_sine.sv]
// ----------------------------------------------------------------------------
// triple_angle_sine
// Sine of a Q8.24 angle by division by three and the triple-angle identity.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and the Q2.30
// sine comes out on o_sine with o_valid high for one cycle, after k divisions
// by three (0 to 16). A single 32x31 multiplier is shared by all steps: each
// division uses it once per 16-bit chunk of the 64-bit magnitude, followed by
// a threshold check, and each triple-angle step uses it twice, then combines.
// busy drops in the cycle the result is shown, so a new start may be taken at
// that edge. The result cannot be held off; capture it when o_valid is high.
// The threshold register is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while busy is low, as the block does not enforce this.
// ----------------------------------------------------------------------------
module triple_angle_sine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic signed [tas_pkg::ANGLE_W-1:0]   i_angle,
    input  logic                                 i_cfg_we,
    input  logic        [tas_pkg::THR_W-1:0]     i_cfg_wdata,
    output logic                                 busy,
    output logic                                 o_valid,
    output logic signed [tas_pkg::SINE_W-1:0]    o_sine,
    output logic                                 o_steps_saturated
);
    import tas_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_DIV, S_EST, S_SQ, S_CU, S_UPD, S_OUT
    } t_state;

    t_state                   r_state;
    logic [THR_W-1:0]         r_thr;
    logic                     r_in_neg;
    logic [MAG_W-1:0]         r_mag;
    logic [1:0]               r_rem;
    logic [CHUNK_IDX_W-1:0]   r_chunk;
    logic [STEP_W-1:0]        r_steps;
    logic                     r_sat;
    logic [MUL_B_W-1:0]       r_m;
    logic                     r_sneg;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_valid;
    logic [SINE_W-1:0]        r_sine;
    logic                     r_sat_out;

    // Input magnitude, most negative angle clamped
    logic [ANGLE_W-1:0]       raw;
    logic [ANGLE_W-1:0]       raw_negd;
    logic [MUL_B_W-1:0]       amag;

    // Shared multiplier
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [PROD_W-1:0]        mul_p;

    // Division by three, one chunk
    logic [DIV_N_W-1:0]       div_n;
    logic [CHUNK_W-1:0]       div_q;
    logic [DIV_N_W-1:0]       div_q3;
    logic [DIV_N_W-1:0]       div_rem_full;
    logic [1:0]               div_r;
    logic                     cmp_ge;

    // Estimate and triple-angle step
    logic [MAG_W-26:0]        e_full;
    logic [MUL_B_W-1:0]       e_sat;
    logic [MUL_A_W-1:0]       m2_rnd;
    logic [32:0]              m3_rnd;
    logic [36:0]              m_x3;
    logic [36:0]              m3_x4;
    logic [36:0]              t_raw;
    logic [36:0]              t_abs;
    logic                     t_neg;
    logic [MUL_B_W-1:0]       t_sat;

    // Final sign and clamp to plus or minus one
    logic [MUL_B_W-1:0]       m_clamp;
    logic                     out_neg;
    logic [SINE_W-1:0]        sine_n;

    assign raw      = i_angle;
    assign raw_negd = ~raw + 32'd1;
    assign amag     = raw[ANGLE_W-1]
                      ? (raw_negd[ANGLE_W-1] ? Q230_MAX : raw_negd[MUL_B_W-1:0])
                      : raw[MUL_B_W-1:0];

    always_comb begin
        unique case (r_state)
            S_DIV: begin
                mul_a = MUL_A_W'(div_n);
                mul_b = DIV3_RECIP;
            end
            S_CU: begin
                mul_a = m2_rnd;
                mul_b = r_m;
            end
            default: begin
                mul_a = {1'b0, r_m};
                mul_b = r_m;
            end
        endcase
    end

    assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    assign div_n        = {r_rem, r_mag[MAG_W-1 -: CHUNK_W]};
    assign div_q        = mul_p[DIV_SHIFT +: CHUNK_W];
    assign div_q3       = {1'b0, div_q, 1'b0} + {2'b00, div_q};
    assign div_rem_full = div_n - div_q3;
    assign div_r        = div_rem_full[1:0];

    // Threshold sits at bit 32 of the magnitude, so only the top word counts
    assign cmp_ge = r_mag[MAG_W-1:32] >= {{(32-THR_W){1'b0}}, r_thr};

    // Round half up from Q8.56 to Q2.30
    assign e_full = {1'b0, r_mag[MAG_W-1:26]} + {{(MAG_W-26){1'b0}}, r_mag[25]};
    assign e_sat  = (e_full > {{(MAG_W-25-MUL_B_W){1'b0}}, Q230_MAX})
                    ? Q230_MAX : e_full[MUL_B_W-1:0];

    assign m2_rnd = r_prod[61:30] + {31'b0, r_prod[29]};
    assign m3_rnd = r_prod[62:30] + {32'b0, r_prod[29]};

    // t = 3m - 4m^3 on magnitudes; sign tracked separately
    assign m_x3  = {6'b0, r_m} + {5'b0, r_m, 1'b0};
    assign m3_x4 = {2'b0, m3_rnd, 2'b00};
    assign t_raw = m_x3 - m3_x4;
    assign t_neg = t_raw[36];
    assign t_abs = t_neg ? (~t_raw + 37'd1) : t_raw;
    assign t_sat = (t_abs > {6'b0, Q230_MAX}) ? Q230_MAX : t_abs[MUL_B_W-1:0];

    assign m_clamp = (r_m > ONE_Q230) ? ONE_Q230 : r_m;
    assign out_neg = r_sneg ^ r_in_neg;
    assign sine_n  = out_neg ? (~{1'b0, m_clamp} + 32'd1) : {1'b0, m_clamp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr   <= THR_RESET;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in_neg <= raw[ANGLE_W-1];
                        r_mag    <= {1'b0, amag, 32'b0};
                        r_steps  <= '0;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (cmp_ge && (r_steps < STEP_W'(MAX_STEPS))) begin
                        r_steps <= r_steps + 1'b1;
                        r_chunk <= '0;
                        r_rem   <= 2'b00;
                        r_state <= S_DIV;
                    end else begin
                        r_sat   <= cmp_ge;
                        r_state <= S_EST;
                    end
                end
                S_DIV: begin
                    // shift the quotient chunk in from the bottom
                    r_mag   <= {r_mag[MAG_W-CHUNK_W-1:0], div_q};
                    r_rem   <= div_r;
                    r_chunk <= r_chunk + 1'b1;
                    if (r_chunk == CHUNK_IDX_W'(NUM_CHUNKS - 1)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_EST: begin
                    r_m    <= e_sat;
                    r_sneg <= 1'b0;
                    if (r_steps == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod  <= mul_p;
                    r_state <= S_CU;
                end
                S_CU: begin
                    r_prod  <= mul_p;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_m     <= t_sat;
                    r_sneg  <= r_sneg ^ t_neg;
                    r_steps <= r_steps - 1'b1;
                    if (r_steps == STEP_W'(1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_OUT: begin
                    r_valid   <= 1'b1;
                    r_sine    <= sine_n;
                    r_sat_out <= r_sat;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_sine            = r_sine;
    assign o_steps_saturated = r_sat_out;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while a transaction is still running");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_sine <= 32'sd1073741824) && (o_sine >= -32'sd1073741824)))
        else $error("sine outside plus or minus one");

    a_step_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_steps != '0) && (r_steps <= STEP_W'(MAX_STEPS))))
        else $error("division count out of range");

endmodule
